### src/bicycle_model_motion_predictor_top_defines.svh
// Assertion macros for the motion predictor.
`ifndef BICYCLE_MODEL_MOTION_PREDICTOR_TOP_DEFINES_SVH
`define BICYCLE_MODEL_MOTION_PREDICTOR_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define BMP_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BMP_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BMP_ASSERT_IMPL(label, clk, rst, prop, msg)
`define BMP_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

### src/bmp_pkg.sv
`default_nettype none
package bmp_pkg;
   localparam int MAX_SUBSTEPS = 16;
   localparam logic signed [15:0] PI_Q13 = 16'sd25736;
   localparam logic signed [16:0] TWO_PI_Q13 = 17'sd51472;
   localparam logic signed [19:0] PI_Q16 = 20'sd205887;
   localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
   localparam logic signed [19:0] CORDIC_GAIN_Q16 = 20'sd39797;

   localparam logic [2:0] CFG_GAIN = 3'd0;
   localparam logic [2:0] CFG_TSTEP = 3'd1;
   localparam logic [2:0] CFG_NSUB = 3'd2;
   localparam logic [2:0] CFG_ALEN = 3'd3;
   localparam logic [2:0] CFG_AINV = 3'd4;
   localparam logic [2:0] CFG_THR = 3'd5;

   localparam logic CMD_INIT = 1'b0;

   // datapath operations
   localparam logic [3:0] OP_NONE   = 4'd0;
   localparam logic [3:0] OP_INIT0  = 4'd1;  // pick speed, load heading/steer, trig(steer)
   localparam logic [3:0] OP_INIT1  = 4'd2;  // rate product 1, trig(heading)
   localparam logic [3:0] OP_INIT2  = 4'd3;  // rate product 2, axle offsets
   localparam logic [3:0] OP_STEER  = 4'd4;  // steer filter
   localparam logic [3:0] OP_INTEG  = 4'd5;  // heading, speed, trig(steer)
   localparam logic [3:0] OP_RATE1  = 4'd6;  // speed*ainv, trig(heading)
   localparam logic [3:0] OP_RATE2  = 4'd7;  // rate, speed*cs
   localparam logic [3:0] OP_POS    = 4'd8;  // p*c, p*s
   localparam logic [3:0] OP_TRIGW  = 4'd9;  // q*ts, write axle, time

   typedef struct packed {
      logic [3:0] op;
   } cmd_type;

   typedef struct packed {
      logic trig_busy;
   } stat_type;

   typedef logic [4:0] sub_count_type;

   function automatic logic signed [19:0] atan_entry(input logic [3:0] i);
      case (i)
         4'd0: atan_entry = 20'sd51472;
         4'd1: atan_entry = 20'sd30385;
         4'd2: atan_entry = 20'sd16055;
         4'd3: atan_entry = 20'sd8150;
         4'd4: atan_entry = 20'sd4091;
         4'd5: atan_entry = 20'sd2047;
         4'd6: atan_entry = 20'sd1024;
         4'd7: atan_entry = 20'sd512;
         4'd8: atan_entry = 20'sd256;
         4'd9: atan_entry = 20'sd128;
         4'd10: atan_entry = 20'sd64;
         4'd11: atan_entry = 20'sd32;
         4'd12: atan_entry = 20'sd16;
         4'd13: atan_entry = 20'sd8;
         4'd14: atan_entry = 20'sd4;
         default: atan_entry = 20'sd2;
      endcase
   endfunction
endpackage
`default_nettype wire

### src/bmp_cordic.sv
`default_nettype none
module bmp_cordic
   import bmp_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic signed [15:0] angle,
   output logic busy,
   output logic signed [18:0] sin_out,
   output logic signed [18:0] cos_out
);
   logic signed [19:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [3:0] i_ff, i_in;
   logic busy_ff, busy_in, flip_ff, flip_in;
   logic signed [19:0] z0;

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff; i_in = i_ff;
      busy_in = busy_ff; flip_in = flip_ff;
      z0 = 20'(angle) <<< 3;
      if (start) begin
         x_in = CORDIC_GAIN_Q16; y_in = '0; i_in = '0; busy_in = 1'b1;
         flip_in = 1'b0; z_in = z0;
         if (z0 > HALF_PI_Q16) begin
            z_in = z0 - PI_Q16; flip_in = 1'b1;
         end else if (z0 < -HALF_PI_Q16) begin
            z_in = z0 + PI_Q16; flip_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (!z_ff[19]) begin
            x_in = x_ff - (y_ff >>> i_ff); y_in = y_ff + (x_ff >>> i_ff);
            z_in = z_ff - atan_entry(i_ff);
         end else begin
            x_in = x_ff + (y_ff >>> i_ff); y_in = y_ff - (x_ff >>> i_ff);
            z_in = z_ff + atan_entry(i_ff);
         end
         i_in = i_ff + 4'd1;
         if (i_ff == 4'd15) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; i_ff <= '0;
      end else begin
         busy_ff <= busy_in; i_ff <= i_in;
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; flip_ff <= flip_in;
   end

   assign busy = busy_ff;
   assign sin_out = flip_ff ? 19'(-y_ff) : 19'(y_ff);
   assign cos_out = flip_ff ? 19'(-x_ff) : 19'(x_ff);
endmodule
`default_nettype wire

### src/bmp_datapath.sv
`default_nettype none
module bmp_datapath
   import bmp_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire cmd_type cmd,
   output stat_type stat,
   input  wire logic [16:0] cfg_gain,
   input  wire logic [15:0] cfg_tstep,
   input  wire logic [20:0] cfg_alen,
   input  wire logic [23:0] cfg_ainv,
   input  wire logic [14:0] cfg_thr,
   input  wire logic signed [31:0] pose_x,
   input  wire logic signed [31:0] pose_y,
   input  wire logic signed [15:0] heading,
   input  wire logic signed [15:0] steer_now,
   input  wire logic signed [15:0] commanded_speed,
   input  wire logic signed [15:0] measured_speed,
   input  wire logic signed [15:0] steer_target,
   input  wire logic signed [15:0] accel,
   output logic signed [31:0] axle_x,
   output logic signed [31:0] axle_y,
   output logic signed [15:0] heading_out,
   output logic signed [15:0] speed_out,
   output logic signed [15:0] steer_out,
   output logic [31:0] pred_time
);
   logic signed [31:0] ax_ff, ax_in, ay_ff, ay_in;
   logic signed [15:0] hd_ff, hd_in, rt_ff, rt_in, sp_ff, sp_in, st_ff, st_in;
   logic [31:0] tm_ff, tm_in;
   // intermediate product registers
   logic signed [18:0] sn_ff, sn_in, cs_ff, cs_in;
   logic signed [31:0] r_ff, r_in;
   logic signed [19:0] p_ff, p_in;
   logic signed [20:0] qx_ff, qx_in, qy_ff, qy_in;

   logic trig_start;
   logic signed [15:0] trig_angle;
   logic trig_busy;
   logic signed [18:0] tsin, tcos;

   logic [16:0] g;
   logic signed [17:0] gs, gi;
   logic signed [35:0] sf;
   logic signed [32:0] dh;
   logic signed [17:0] hsum;
   logic signed [32:0] da;
   logic signed [17:0] ssum;
   logic signed [40:0] rv;
   logic signed [50:0] rr;
   logic signed [35:0] pc;
   logic signed [39:0] q1, q2;
   logic signed [37:0] qt1, qt2;
   logic signed [33:0] nx, ny;
   logic signed [16:0] dvs;
   logic [16:0] dabs;
   logic signed [40:0] lc, ls;
   logic signed [33:0] ix, iy;
   logic [32:0] tsum;

   bmp_cordic u_cordic (
      .clock(clock), .reset(reset), .start(trig_start), .angle(trig_angle),
      .busy(trig_busy), .sin_out(tsin), .cos_out(tcos)
   );

   function automatic logic signed [15:0] sat16(input logic signed [50:0] v);
      if (v > 51'sd32767) sat16 = 16'sh7fff;
      else if (v < -51'sd32768) sat16 = 16'sh8000;
      else sat16 = 16'(v);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      if (v > 34'sd2147483647) sat32 = 32'sh7fffffff;
      else if (v < -34'sd2147483648) sat32 = 32'sh80000000;
      else sat32 = 32'(v);
   endfunction

   always_comb begin
      ax_in = ax_ff; ay_in = ay_ff; hd_in = hd_ff; rt_in = rt_ff;
      sp_in = sp_ff; st_in = st_ff; tm_in = tm_ff;
      sn_in = sn_ff; cs_in = cs_ff; r_in = r_ff; p_in = p_ff;
      qx_in = qx_ff; qy_in = qy_ff;
      trig_start = 1'b0; trig_angle = st_ff;
      g = (cfg_gain > 17'd65536) ? 17'd65536 : cfg_gain;
      gs = 18'sd65536 - $signed({1'b0, g});
      gi = $signed({1'b0, g});
      sf = gs * st_ff + gi * steer_target;
      dh = rt_ff * $signed({1'b0, cfg_tstep});
      hsum = 18'(hd_ff) + 18'(dh >>> 16);
      da = accel * $signed({1'b0, cfg_tstep});
      ssum = 18'(sp_ff) + 18'(da >>> 16);
      rv = sp_ff * $signed({1'b0, cfg_ainv});
      rr = 51'(r_ff) * 51'(sn_ff);
      pc = sp_ff * cs_ff;
      q1 = p_ff * tcos;
      q2 = p_ff * tsin;
      qt1 = qx_ff * $signed({1'b0, cfg_tstep});
      qt2 = qy_ff * $signed({1'b0, cfg_tstep});
      nx = 34'(ax_ff) + 34'(qt1 >>> 12);
      ny = 34'(ay_ff) + 34'(qt2 >>> 12);
      dvs = 17'(measured_speed) - 17'(commanded_speed);
      dabs = dvs[16] ? 17'(-dvs) : 17'(dvs);
      lc = $signed({1'b0, cfg_alen}) * tcos;
      ls = $signed({1'b0, cfg_alen}) * tsin;
      ix = 34'(pose_x) - 34'(lc >>> 16);
      iy = 34'(pose_y) - 34'(ls >>> 16);
      tsum = {1'b0, tm_ff} + {17'd0, cfg_tstep};
      case (cmd.op)
         OP_INIT0: begin
            sp_in = (dabs > {2'b0, cfg_thr}) ? measured_speed : commanded_speed;
            hd_in = heading; st_in = steer_now; tm_in = '0;
            trig_start = 1'b1; trig_angle = steer_now;
         end
         OP_INIT1: begin
            sn_in = tsin;
            r_in = 32'(rv >>> 15);
            trig_start = 1'b1; trig_angle = hd_ff;
         end
         OP_INIT2: begin
            rt_in = sat16(rr >>> 16);
            ax_in = sat32(ix); ay_in = sat32(iy);
         end
         OP_STEER: st_in = 16'(sf >>> 16);
         OP_INTEG: begin
            if (hsum > 18'(PI_Q13)) hd_in = 16'(hsum - 18'(TWO_PI_Q13));
            else if (hsum < -18'(PI_Q13)) hd_in = 16'(hsum + 18'(TWO_PI_Q13));
            else hd_in = 16'(hsum);
            sp_in = sat16(51'(ssum));
            trig_start = 1'b1; trig_angle = st_ff;
         end
         OP_RATE1: begin
            sn_in = tsin; cs_in = tcos;
            r_in = 32'(rv >>> 15);
            trig_start = 1'b1; trig_angle = hd_ff;
         end
         OP_RATE2: begin
            rt_in = sat16(rr >>> 16);
            p_in = 20'(pc >>> 16);
         end
         OP_POS: begin
            qx_in = 21'(q1 >>> 16); qy_in = 21'(q2 >>> 16);
         end
         OP_TRIGW: begin
            ax_in = sat32(nx); ay_in = sat32(ny);
            tm_in = tsum[32] ? 32'hffffffff : tsum[31:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ax_ff <= '0; ay_ff <= '0; hd_ff <= '0; rt_ff <= '0;
         sp_ff <= '0; st_ff <= '0; tm_ff <= '0;
      end else begin
         ax_ff <= ax_in; ay_ff <= ay_in; hd_ff <= hd_in; rt_ff <= rt_in;
         sp_ff <= sp_in; st_ff <= st_in; tm_ff <= tm_in;
      end
      sn_ff <= sn_in; cs_ff <= cs_in; r_ff <= r_in; p_ff <= p_in;
      qx_ff <= qx_in; qy_ff <= qy_in;
   end

   assign stat.trig_busy = trig_busy;
   assign axle_x = ax_ff;
   assign axle_y = ay_ff;
   assign heading_out = hd_ff;
   assign speed_out = sp_ff;
   assign steer_out = st_ff;
   assign pred_time = tm_ff;
endmodule
`default_nettype wire

### src/bmp_control.sv
`default_nettype none
module bmp_control
   import bmp_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic command,
   input  wire logic [4:0] cfg_nsub,
   input  wire stat_type stat,
   output cmd_type cmd,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic rsp_last
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_I1W   = 4'd1;
   localparam logic [3:0] S_I1    = 4'd2;
   localparam logic [3:0] S_I2W   = 4'd3;
   localparam logic [3:0] S_STEER = 4'd4;
   localparam logic [3:0] S_INTEG = 4'd5;
   localparam logic [3:0] S_SW    = 4'd6;
   localparam logic [3:0] S_R1    = 4'd7;
   localparam logic [3:0] S_HW    = 4'd8;
   localparam logic [3:0] S_R2    = 4'd9;
   localparam logic [3:0] S_POS   = 4'd10;
   localparam logic [3:0] S_OUT   = 4'd11;

   logic [3:0] state_ff, state_in;
   sub_count_type left_ff, left_in;
   logic out_ff, out_in;
   sub_count_type nsub;
   logic req_fire;

   assign nsub = (cfg_nsub > 5'(MAX_SUBSTEPS)) ? 5'(MAX_SUBSTEPS) : cfg_nsub;
   assign req_ready = (state_ff == S_IDLE) && !out_ff;
   assign req_fire = req_valid && req_ready;

   always_comb begin
      state_in = state_ff; left_in = left_ff; out_in = out_ff;
      cmd.op = OP_NONE;
      if (out_ff && rsp_ready) out_in = 1'b0;
      case (state_ff)
         S_IDLE: if (req_fire) begin
            if (command == CMD_INIT) begin
               cmd.op = OP_INIT0; state_in = S_I1W;
            end else if (nsub != '0) begin
               left_in = nsub; state_in = S_STEER;
            end
         end
         S_I1W: if (!stat.trig_busy) state_in = S_I1;
         S_I1: begin
            cmd.op = OP_INIT1; state_in = S_I2W;
         end
         S_I2W: if (!stat.trig_busy) begin
            cmd.op = OP_INIT2; state_in = S_IDLE;
         end
         S_STEER: if (!out_ff) begin
            cmd.op = OP_STEER; state_in = S_INTEG;
         end
         S_INTEG: begin
            cmd.op = OP_INTEG; state_in = S_SW;
         end
         S_SW: if (!stat.trig_busy) state_in = S_R1;
         S_R1: begin
            cmd.op = OP_RATE1; state_in = S_HW;
         end
         S_HW: if (!stat.trig_busy) state_in = S_R2;
         S_R2: begin
            cmd.op = OP_RATE2; state_in = S_POS;
         end
         S_POS: begin
            cmd.op = OP_POS; state_in = S_OUT;
         end
         S_OUT: begin
            cmd.op = OP_TRIGW; out_in = 1'b1;
            left_in = left_ff - 5'd1;
            state_in = (left_ff == 5'd1) ? S_IDLE : S_STEER;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; left_ff <= '0; out_ff <= 1'b0;
      end else begin
         state_ff <= state_in; left_ff <= left_in; out_ff <= out_in;
      end
   end

   logic last_ff, last_in;
   assign last_in = (state_ff == S_OUT) ? (left_ff == 5'd1) : last_ff;
   always_ff @(posedge clock) last_ff <= last_in;

   assign rsp_valid = out_ff;
   assign rsp_last = last_ff;
endmodule
`default_nettype wire

### src/bicycle_model_motion_predictor_top.sv
// Kinematic bicycle motion predictor. An init request gives no response; a step request
// gives one response per substep, and each substep runs two 16-iteration passes of the
// shared CORDIC unit. The next substep starts only once the previous response is taken.
// One request is in work at a time.
`default_nettype none
`include "bicycle_model_motion_predictor_top_defines.svh"
module bicycle_model_motion_predictor_top
   import bmp_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic req_command,
   input  wire logic signed [31:0] req_pose_x,
   input  wire logic signed [31:0] req_pose_y,
   input  wire logic signed [15:0] req_heading,
   input  wire logic signed [15:0] req_steer_now,
   input  wire logic signed [15:0] req_commanded_speed,
   input  wire logic signed [15:0] req_measured_speed,
   input  wire logic signed [15:0] req_steer_target,
   input  wire logic signed [15:0] req_accel,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic signed [31:0] rsp_axle_x,
   output logic signed [31:0] rsp_axle_y,
   output logic signed [15:0] rsp_heading_out,
   output logic signed [15:0] rsp_speed_out,
   output logic signed [15:0] rsp_steer_out,
   output logic [31:0] rsp_pred_time,
   output logic rsp_last,
   input  wire logic csr_we,
   input  wire logic [2:0] csr_index,
   input  wire logic [23:0] csr_wdata
);
   logic [16:0] gain_ff;
   logic [15:0] tstep_ff;
   logic [4:0] nsub_ff;
   logic [20:0] alen_ff;
   logic [23:0] ainv_ff;
   logic [14:0] thr_ff;
   cmd_type cmd;
   stat_type stat;
   logic cmd_ff;
   logic signed [15:0] tgt_ff, acc_ff;
   logic signed [31:0] px_ff, py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= 17'd16384; tstep_ff <= 16'd6554; nsub_ff <= 5'd4;
         alen_ff <= 21'd19661; ainv_ff <= 24'd218453; thr_ff <= 15'd2048;
      end else if (csr_we) begin
         case (csr_index)
            CFG_GAIN: gain_ff <= csr_wdata[16:0];
            CFG_TSTEP: tstep_ff <= csr_wdata[15:0];
            CFG_NSUB: nsub_ff <= csr_wdata[4:0];
            CFG_ALEN: alen_ff <= csr_wdata[20:0];
            CFG_AINV: ainv_ff <= csr_wdata[23:0];
            CFG_THR: thr_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // hold the steer target, acceleration, command and pose of the request for the whole request
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         tgt_ff <= req_steer_target; acc_ff <= req_accel; cmd_ff <= req_command;
         px_ff <= req_pose_x; py_ff <= req_pose_y;
      end
   end

   bmp_control u_control (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .command(req_command), .cfg_nsub(nsub_ff), .stat(stat), .cmd(cmd),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_last(rsp_last)
   );

   bmp_datapath u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .cfg_gain(gain_ff), .cfg_tstep(tstep_ff), .cfg_alen(alen_ff),
      .cfg_ainv(ainv_ff), .cfg_thr(thr_ff),
      .pose_x(px_ff), .pose_y(py_ff), .heading(req_heading),
      .steer_now(req_steer_now), .commanded_speed(req_commanded_speed),
      .measured_speed(req_measured_speed), .steer_target(tgt_ff), .accel(acc_ff),
      .axle_x(rsp_axle_x), .axle_y(rsp_axle_y), .heading_out(rsp_heading_out),
      .speed_out(rsp_speed_out), .steer_out(rsp_steer_out), .pred_time(rsp_pred_time)
   );

   `BMP_ASSERT_IMPL(a_no_req_while_rsp, clock, reset, rsp_valid |-> !req_ready, "request taken while response pending")
   `BMP_ASSERT_IMPL(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_axle_x) && $stable(rsp_last), "response dropped")
   `BMP_ASSERT_IMPL(a_rsp_from_step, clock, reset, $rose(rsp_valid) |-> cmd_ff, "response from init request")
   `BMP_ASSERT_NORST(a_reset_idle, clock, $past(reset) |-> !rsp_valid, "response after reset")
endmodule
`default_nettype wire
